// ===== rtl/tst_pkg.sv =====
`default_nettype none
package tst_pkg;

    localparam int TONE_COUNT    = 64;
    localparam int PATTERN_COUNT = 16;
    localparam int STEPS         = 16;
    localparam int SONG_LEN      = 2;
    localparam int CHANNELS      = 3;

    localparam int TONE_AW = $clog2(TONE_COUNT);
    localparam int PAT_AW  = $clog2(PATTERN_COUNT * STEPS);
    localparam int STEP_W  = $clog2(STEPS);
    localparam int SONG_PW = (SONG_LEN > 1) ? $clog2(SONG_LEN) : 1;
    localparam int SONG_AW = $clog2(CHANNELS * SONG_LEN);

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 88;

    localparam logic [7:0] REST_MARK = 8'd255;
    localparam logic [7:0] BEND_CODE = 8'd2;
    localparam logic [7:0] TPS_RESET = 8'd8;

    localparam logic [6:0] VOL_LEAD   = 7'd64;
    localparam logic [5:0] VOL_BASS   = 6'd48;
    localparam logic [5:0] VOL_THIRD  = 6'd32;
    localparam logic [6:0] DECAY_LEAD = 7'd8;
    localparam logic [5:0] DECAY_BASS = 6'd4;

    localparam int LOOKUPS = 6;
    localparam int TAG_W   = 3;
    localparam logic [TAG_W-1:0] TAG_LEAD      = 3'd0;
    localparam logic [TAG_W-1:0] TAG_LEAD_NEXT = 3'd1;
    localparam logic [TAG_W-1:0] TAG_BASS      = 3'd2;
    localparam logic [TAG_W-1:0] TAG_BASS_NEXT = 3'd3;
    localparam logic [TAG_W-1:0] TAG_THIRD     = 3'd4;
    localparam logic [TAG_W-1:0] TAG_TARGET    = 3'd5;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_TONE_WR   = 3'd1,
        CMD_PAT_WR    = 3'd2,
        CMD_MOD_WR    = 3'd3,
        CMD_SONG_WR   = 3'd4,
        CMD_NOISE_SET = 3'd5,
        CMD_RESTART   = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic        en;
        logic [2:0]  cmd;
        logic [1:0]  channel;
        logic [7:0]  table_index;
        logic [3:0]  step_index;
        logic [15:0] value;
    } t_wr;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [1:0]         ch;
        logic [SONG_PW-1:0] pos;
        logic [STEP_W:0]    step;
    } t_req;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [15:0]      tone;
        logic [7:0]       entry;
        logic [7:0]       modifier;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/tst_tables.sv =====
`default_nettype none
module tst_tables (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  tst_pkg::t_wr   i_wr,
    input  tst_pkg::t_req  i_req,
    output tst_pkg::t_res  o_res
);
    import tst_pkg::*;

    logic [15:0] tone_mem [0:TONE_COUNT-1];
    logic [7:0]  pat_mem  [0:PATTERN_COUNT*STEPS-1];
    logic [7:0]  mod_mem  [0:PATTERN_COUNT*STEPS-1];
    logic [7:0]  song_mem [0:CHANNELS*SONG_LEN-1];

    logic               tone_we, pat_we, mod_we, song_we;
    logic [TONE_AW-1:0] tone_wa;
    logic [PAT_AW-1:0]  pat_wa;
    logic [SONG_AW-1:0] song_wa;

    assign tone_we = i_wr.en && i_wr.cmd == CMD_TONE_WR
                     && 32'(i_wr.table_index) < TONE_COUNT;
    assign pat_we  = i_wr.en && i_wr.cmd == CMD_PAT_WR
                     && 32'(i_wr.table_index) < PATTERN_COUNT
                     && 32'(i_wr.step_index) < STEPS;
    assign mod_we  = i_wr.en && i_wr.cmd == CMD_MOD_WR
                     && 32'(i_wr.table_index) < PATTERN_COUNT
                     && 32'(i_wr.step_index) < STEPS;
    assign song_we = i_wr.en && i_wr.cmd == CMD_SONG_WR
                     && 32'(i_wr.channel) < CHANNELS
                     && 32'(i_wr.table_index) < SONG_LEN;
    assign tone_wa = TONE_AW'(i_wr.table_index);
    assign pat_wa  = PAT_AW'(32'(i_wr.table_index) * STEPS + 32'(i_wr.step_index));
    assign song_wa = SONG_AW'(32'(i_wr.channel) * SONG_LEN + 32'(i_wr.table_index));

    always_ff @(posedge i_clk) begin
        if (tone_we) begin
            tone_mem[tone_wa] <= i_wr.value;
        end
        if (pat_we) begin
            pat_mem[pat_wa] <= i_wr.value[7:0];
        end
        if (mod_we) begin
            mod_mem[pat_wa] <= i_wr.value[7:0];
        end
        if (song_we) begin
            song_mem[song_wa] <= i_wr.value[7:0];
        end
    end

    // lookup chain: song entry -> pattern/modifier -> tone word
    logic [SONG_AW-1:0] song_ra;
    logic [7:0]         r_song_q;
    logic               r_s1_valid;
    logic [TAG_W-1:0]   r_s1_tag;
    logic [STEP_W:0]    r_s1_step;

    assign song_ra = SONG_AW'(32'(i_req.ch) * SONG_LEN + 32'(i_req.pos));

    always_ff @(posedge i_clk) begin
        r_song_q  <= song_mem[song_ra];
        r_s1_tag  <= i_req.tag;
        r_s1_step <= i_req.step;
    end

    logic              pat_ok;
    logic [PAT_AW-1:0] pat_ra;
    logic [7:0]        r_pat_q, r_mod_q, r_s2_entry;
    logic              r_s2_valid, r_s2_ok;
    logic [TAG_W-1:0]  r_s2_tag;

    assign pat_ok = 32'(r_song_q) < PATTERN_COUNT && 32'(r_s1_step) < STEPS;
    assign pat_ra = PAT_AW'(32'(r_song_q) * STEPS + 32'(r_s1_step));

    always_ff @(posedge i_clk) begin
        r_pat_q    <= pat_mem[pat_ra];
        r_mod_q    <= mod_mem[pat_ra];
        r_s2_ok    <= pat_ok;
        r_s2_entry <= r_song_q;
        r_s2_tag   <= r_s1_tag;
    end

    logic             tone_ok;
    logic [15:0]      r_tone_q;
    logic             r_s3_valid, r_s3_ok;
    logic [TAG_W-1:0] r_s3_tag;
    logic [7:0]       r_s3_entry, r_s3_mod;

    assign tone_ok = r_s2_ok && 32'(r_pat_q) < TONE_COUNT;

    always_ff @(posedge i_clk) begin
        r_tone_q   <= tone_mem[TONE_AW'(r_pat_q)];
        r_s3_ok    <= tone_ok;
        r_s3_mod   <= r_s2_ok ? r_mod_q : 8'd0;
        r_s3_entry <= r_s2_entry;
        r_s3_tag   <= r_s2_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign o_res.valid    = r_s3_valid;
    assign o_res.tag      = r_s3_tag;
    assign o_res.tone     = r_s3_ok ? r_tone_q : 16'd0;
    assign o_res.entry    = r_s3_entry;
    assign o_res.modifier = r_s3_mod;

endmodule
`default_nettype wire

// ===== rtl/tracker_sequencer_tick.sv =====
`default_nettype none
// Three-channel pattern sequencer. Every accepted word returns one result word holding
// the channel tone words and volumes, the noise levels and the play position after the
// command. Table writes, noise sets and restarts finish in the cycle they are accepted,
// so they stream at one word per clock while result words are taken. A tick runs six
// table lookups, one per cycle, through the shared song, pattern and tone memory read
// ports; each lookup passes a chain of registered reads: song entry, pattern and
// modifier, tone word. The block issues the six lookups, waits while the last one
// returns, then updates the play state and loads the result word once the output
// register is free; only then is the next word taken. The input is ready only while
// no tick is in progress and the output register is empty or is being taken.
// ticks_per_step may be written only while no word is in flight; zero acts as one.
module tracker_sequencer_tick (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // table_index[7:0], step_index[11:8], value[27:12], zero fill
    input  wire  [tst_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // command[2:0], channel[4:3]
    input  wire  [tst_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // freq_lead, freq_bass, freq_third, vol_lead, vol_bass, vol_third,
    // noise_a, noise_b, step_now, song_now
    output logic [tst_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [7:0]                       i_cfg_data
);
    import tst_pkg::*;

    t_wr  wr;
    t_req req;
    t_res res;

    tst_tables u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_req   (req),
        .o_res   (res)
    );

    t_state             r_state, n_state;
    logic [TAG_W-1:0]   r_cnt, n_cnt;
    logic [15:0]        r_freq0, r_freq1, r_freq2, n_freq0, n_freq1, n_freq2;
    logic [6:0]         r_vol0, n_vol0;
    logic [5:0]         r_vol1, r_vol2, n_vol1, n_vol2;
    logic [7:0]         r_noise_a, r_noise_b, n_noise_a, n_noise_b;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [SONG_PW-1:0] r_song, n_song;
    logic [7:0]         r_div, n_div;
    logic [7:0]         r_tps;
    logic               r_out_valid, n_load;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [15:0] r_tone [0:LOOKUPS-1];
    logic [7:0]  r_ent_lead, r_mod_lead, r_ent_bass, r_ent_third;

    logic [2:0]  in_cmd;
    logic [1:0]  in_ch;
    logic [15:0] in_value;
    logic        out_free, accept;

    assign in_cmd   = i_s_tuser[2:0];
    assign in_ch    = i_s_tuser[4:3];
    assign in_value = i_s_tdata[27:12];
    assign out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept   = i_s_tvalid && o_s_tready;

    assign wr.en          = accept;
    assign wr.cmd         = in_cmd;
    assign wr.channel     = in_ch;
    assign wr.table_index = i_s_tdata[7:0];
    assign wr.step_index  = i_s_tdata[11:8];
    assign wr.value       = in_value;

    // lookup requests
    logic [STEP_W:0]    step_cur, step_nx;
    logic [SONG_PW-1:0] pos_next;

    assign step_cur = {1'b0, r_step};
    assign step_nx  = step_cur + 1'b1;
    assign pos_next = (32'(r_song) == SONG_LEN - 1) ? '0 : r_song + 1'b1;

    always_comb begin
        req.valid = (r_state == ST_ISSUE);
        req.tag   = r_cnt;
        req.ch    = 2'd0;
        req.pos   = r_song;
        req.step  = step_cur;
        case (r_cnt)
            TAG_LEAD:      req.ch = 2'd0;
            TAG_LEAD_NEXT: req.step = step_nx;
            TAG_BASS:      req.ch = 2'd1;
            TAG_BASS_NEXT: begin
                req.ch   = 2'd1;
                req.step = step_nx;
            end
            TAG_THIRD:     req.ch = 2'd2;
            TAG_TARGET: begin
                req.pos  = pos_next;
                req.step = '0;
            end
            default:       req.valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_tone[res.tag] <= res.tone;
            if (res.tag == TAG_LEAD) begin
                r_ent_lead <= res.entry;
                r_mod_lead <= res.modifier;
            end
            if (res.tag == TAG_BASS) begin
                r_ent_bass <= res.entry;
            end
            if (res.tag == TAG_THIRD) begin
                r_ent_third <= res.entry;
            end
        end
    end

    // tick arithmetic on the gathered lookups
    logic        last_step, bend_on;
    logic [6:0]  vol0_dec;
    logic [5:0]  vol1_dec;
    logic [15:0] target, freq0_bend;
    logic [16:0] bend_sum;
    logic [7:0]  speed;
    logic [8:0]  div_inc;
    logic        step_due;

    assign last_step = (32'(r_step) == STEPS - 1);
    assign vol0_dec = (r_vol0 != 7'd0 && !last_step
                       && r_tone[TAG_LEAD] != r_tone[TAG_LEAD_NEXT])
                      ? ((r_vol0 > DECAY_LEAD) ? r_vol0 - DECAY_LEAD : 7'd0) : r_vol0;
    assign vol1_dec = (r_vol1 != 6'd0 && !last_step
                       && r_tone[TAG_BASS] != r_tone[TAG_BASS_NEXT])
                      ? ((r_vol1 > DECAY_BASS) ? r_vol1 - DECAY_BASS : 6'd0) : r_vol1;
    assign bend_on  = r_ent_lead != REST_MARK && r_mod_lead == BEND_CODE;
    assign target   = last_step ? r_tone[TAG_TARGET] : r_tone[TAG_LEAD];
    assign bend_sum = {1'b0, target} + {1'b0, r_freq0};
    assign freq0_bend = (bend_on && r_freq0 != 16'd0 && target != 16'd0)
                        ? bend_sum[16:1] : r_freq0;
    assign speed    = (r_tps == 8'd0) ? 8'd1 : r_tps;
    assign div_inc  = {1'b0, r_div} + 9'd1;
    assign step_due = div_inc >= {1'b0, speed};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_freq0   = r_freq0;
        n_freq1   = r_freq1;
        n_freq2   = r_freq2;
        n_vol0    = r_vol0;
        n_vol1    = r_vol1;
        n_vol2    = r_vol2;
        n_noise_a = r_noise_a;
        n_noise_b = r_noise_b;
        n_step    = r_step;
        n_song    = r_song;
        n_div     = r_div;
        n_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_load = (in_cmd != CMD_TICK);
                    case (in_cmd)
                        CMD_TICK: begin
                            n_state = ST_ISSUE;
                            n_cnt   = '0;
                        end
                        CMD_NOISE_SET: begin
                            if (in_ch == 2'd0) begin
                                n_noise_a = in_value[7:0];
                            end
                            if (in_ch == 2'd1) begin
                                n_noise_b = in_value[7:0];
                            end
                        end
                        CMD_RESTART: begin
                            n_step = '0;
                            n_song = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == TAG_TARGET) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res.valid && res.tag == TAG_TARGET) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state   = ST_IDLE;
                    n_load    = 1'b1;
                    n_noise_a = {1'b0, r_noise_a[7:1]};
                    n_noise_b = {1'b0, r_noise_b[7:1]};
                    n_vol0    = vol0_dec;
                    n_vol1    = vol1_dec;
                    n_freq0   = freq0_bend;
                    if (!step_due) begin
                        n_div = div_inc[7:0];
                    end else begin
                        n_div = 8'd0;
                        // retrigger: lead and bass only on a tone change
                        if (r_ent_lead == REST_MARK) begin
                            n_vol0 = 7'd0;
                        end else if (freq0_bend != r_tone[TAG_LEAD]) begin
                            n_freq0 = r_tone[TAG_LEAD];
                            n_vol0  = VOL_LEAD;
                        end
                        if (r_ent_bass == REST_MARK) begin
                            n_vol1 = 6'd0;
                        end else if (r_freq1 != r_tone[TAG_BASS]) begin
                            n_freq1 = r_tone[TAG_BASS];
                            n_vol1  = VOL_BASS;
                        end
                        if (r_ent_third == REST_MARK) begin
                            n_vol2 = 6'd0;
                        end else begin
                            n_freq2 = r_tone[TAG_THIRD];
                            n_vol2  = VOL_THIRD;
                        end
                        if (last_step) begin
                            n_step = '0;
                            n_song = pos_next;
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_freq0     <= '0;
            r_freq1     <= '0;
            r_freq2     <= '0;
            r_vol0      <= '0;
            r_vol1      <= '0;
            r_vol2      <= '0;
            r_noise_a   <= '0;
            r_noise_b   <= '0;
            r_step      <= '0;
            r_song      <= '0;
            r_div       <= '0;
            r_tps       <= TPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_freq0   <= n_freq0;
            r_freq1   <= n_freq1;
            r_freq2   <= n_freq2;
            r_vol0    <= n_vol0;
            r_vol1    <= n_vol1;
            r_vol2    <= n_vol2;
            r_noise_a <= n_noise_a;
            r_noise_b <= n_noise_b;
            r_step    <= n_step;
            r_song    <= n_song;
            r_div     <= n_div;
            if (i_cfg_valid) begin
                r_tps <= i_cfg_data;
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_data <= {n_song[0], n_step, n_noise_b, n_noise_a,
                           n_vol2, n_vol1, n_vol0, n_freq2, n_freq1, n_freq0};
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== rtl/tst_chk.sv =====
`default_nettype none
module tst_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_tvalid,
    input wire                             o_s_tready,
    input wire [tst_pkg::IN_USER_W-1:0]    i_s_tuser,
    input wire                             o_m_tvalid,
    input wire                             i_m_tready,
    input wire [tst_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import tst_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word present after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser[2:0] != CMD_TICK |=> o_m_tvalid)
        else $error("non-tick word gave no result next cycle");

    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[54:48] <= VOL_LEAD)
        else $error("lead volume out of range");

    a_third_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[66:61] == 6'd0 || o_m_tdata[66:61] == VOL_THIRD))
        else $error("third channel volume not full or silent");

endmodule

bind tracker_sequencer_tick tst_chk u_tst_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import tst_pkg::*;

    typedef struct {
        logic [15:0] freq_lead, freq_bass, freq_third;
        logic [6:0]  vol_lead;
        logic [5:0]  vol_bass, vol_third;
        logic [7:0]  noise_a, noise_b;
        logic [3:0]  step_now;
        logic        song_now;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata = '0;
    logic [4:0]  i_s_tuser = '0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    wire         o_s_tready, o_m_tvalid, o_cfg_ready;
    wire  [87:0] o_m_tdata;

    tracker_sequencer_tick uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] tone_mem [TONE_COUNT];
    logic [7:0]  pat_mem [PATTERN_COUNT*STEPS];
    logic [7:0]  mod_mem [PATTERN_COUNT*STEPS];
    logic [7:0]  song_mem [3*SONG_LEN];
    logic [15:0] ch_freq [3];
    int          ch_vol [3];
    logic [7:0]  noise_lvl [2];
    int          step_pos, song_pos, tick_div;
    logic [7:0]  speed_reg = TPS_RESET;

    t_status     status_q [$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;
    int          hold_cycles = 0;

    function automatic int song_at(int ch, int pos);
        return song_mem[ch*SONG_LEN + pos % SONG_LEN];
    endfunction

    function automatic logic [15:0] tone_at(int entry, int step);
        int idx;
        if (entry >= PATTERN_COUNT || step >= STEPS) return 16'd0;
        idx = pat_mem[entry*STEPS + step];
        if (idx >= TONE_COUNT) return 16'd0;
        return tone_mem[idx];
    endfunction

    function automatic void decay_vol(int ch, int amount);
        int entry;
        entry = song_at(ch, song_pos);
        if (step_pos + 1 < STEPS && tone_at(entry, step_pos) != tone_at(entry, step_pos + 1))
            ch_vol[ch] = (ch_vol[ch] > amount) ? ch_vol[ch] - amount : 0;
    endfunction

    function automatic void retrig(int ch, int level, bit always_on);
        int entry;
        logic [15:0] t;
        entry = song_at(ch, song_pos);
        if (entry == REST_MARK) begin
            ch_vol[ch] = 0;
            return;
        end
        t = tone_at(entry, step_pos);
        if (always_on || ch_freq[ch] != t) begin
            ch_freq[ch] = t;
            ch_vol[ch] = level;
        end
    endfunction

    function automatic void frame_tick();
        int e0, speed;
        logic [16:0] target;
        noise_lvl[0] = noise_lvl[0] >> 1;
        noise_lvl[1] = noise_lvl[1] >> 1;
        if (ch_vol[0] > 0) decay_vol(0, 8);
        if (ch_vol[1] > 0) decay_vol(1, 4);
        e0 = song_at(0, song_pos);
        if (e0 != REST_MARK && e0 < PATTERN_COUNT &&
            mod_mem[e0*STEPS + step_pos] == BEND_CODE) begin
            if (step_pos == STEPS - 1)
                target = tone_at(song_at(0, (song_pos + 1) % SONG_LEN), 0);
            else
                target = tone_at(e0, step_pos);
            if (ch_freq[0] != 0 && target != 0)
                ch_freq[0] = 16'((target + ch_freq[0]) >> 1);
        end
        speed = (speed_reg == 0) ? 1 : speed_reg;
        tick_div++;
        if (tick_div < speed) return;
        tick_div = 0;
        retrig(0, 64, 1'b0);
        retrig(1, 48, 1'b0);
        retrig(2, 32, 1'b1);
        step_pos++;
        if (step_pos >= STEPS) begin
            step_pos = 0;
            song_pos = (song_pos + 1) % SONG_LEN;
        end
    endfunction

    function automatic t_status apply_command(t_cmd cmd, int ch, int ti, int si,
                                              logic [15:0] val);
        t_status s;
        case (cmd)
            CMD_TICK:      frame_tick();
            CMD_TONE_WR:   if (ti < TONE_COUNT) tone_mem[ti] = val;
            CMD_PAT_WR:    if (ti < PATTERN_COUNT && si < STEPS)
                               pat_mem[ti*STEPS + si] = val[7:0];
            CMD_MOD_WR:    if (ti < PATTERN_COUNT && si < STEPS)
                               mod_mem[ti*STEPS + si] = val[7:0];
            CMD_SONG_WR:   if (ch < 3 && ti < SONG_LEN) song_mem[ch*SONG_LEN + ti] = val[7:0];
            CMD_NOISE_SET: if (ch < 2) noise_lvl[ch] = val[7:0];
            CMD_RESTART: begin
                step_pos = 0;
                song_pos = 0;
            end
            default: ;
        endcase
        s.freq_lead  = ch_freq[0];
        s.freq_bass  = ch_freq[1];
        s.freq_third = ch_freq[2];
        s.vol_lead   = 7'(ch_vol[0]);
        s.vol_bass   = 6'(ch_vol[1]);
        s.vol_third  = 6'(ch_vol[2]);
        s.noise_a    = noise_lvl[0];
        s.noise_b    = noise_lvl[1];
        s.step_now   = 4'(step_pos);
        s.song_now   = 1'(song_pos);
        return s;
    endfunction

    // drive one command word, predict on acceptance; valid stays up for the next call
    task automatic send_word(t_cmd cmd, int ch, int ti, int si, logic [15:0] val);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(99) < 37) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {4'd0, val, 4'(si), 8'(ti)};
        i_s_tuser  = {2'(ch), 3'(cmd)};
        do @(posedge i_clk); while (!o_s_tready);
        status_q.push_back(apply_command(cmd, ch, ti, si, val));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_speed(logic [7:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        speed_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        t_status e;
        logic [15:0] ev [10];
        logic [15:0] av [10];
        bit bad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_m_tdata);
            end else begin
                e = status_q.pop_front();
                ev = '{e.freq_lead, e.freq_bass, e.freq_third, e.vol_lead, e.vol_bass,
                       e.vol_third, e.noise_a, e.noise_b, e.step_now, e.song_now};
                av = '{o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32],
                       o_m_tdata[54:48], o_m_tdata[60:55], o_m_tdata[66:61],
                       o_m_tdata[74:67], o_m_tdata[82:75], o_m_tdata[86:83],
                       o_m_tdata[87]};
                bad = 1'b0;
                for (int k = 0; k < 10; k++)
                    if (ev[k] !== av[k]) begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("field %0d mismatch: expected %h got %h", k, ev[k], av[k]);
                    end
                if (bad) mismatches++;
            end
        end
    end

    task automatic test_load_tables();
        for (int i = 0; i < TONE_COUNT; i++)
            send_word(CMD_TONE_WR, 0, i, 0, (i == 0) ? 16'hFFFF : 16'($urandom));
        for (int i = 0; i < PATTERN_COUNT*STEPS; i++) begin
            send_word(CMD_PAT_WR, 0, i / STEPS, i % STEPS,
                      ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(63)));
            send_word(CMD_MOD_WR, 0, i / STEPS, i % STEPS,
                      ($urandom_range(2) == 0) ? 16'(BEND_CODE) : 16'($urandom));
        end
        for (int i = 0; i < 3*SONG_LEN; i++)
            send_word(CMD_SONG_WR, i / SONG_LEN, i % SONG_LEN, 0, 16'($urandom_range(15)));
    endtask

    task automatic test_directed();
        send_word(CMD_NOISE_SET, 0, 0, 0, 16'hFFFF);
        send_word(CMD_NOISE_SET, 1, 0, 0, 16'h00FF);
        send_word(CMD_NOISE_SET, 2, 0, 0, 16'h1234);       // ignored
        send_word(CMD_NOISE_SET, 3, 255, 15, 16'h5678);    // ignored
        send_word(CMD_TONE_WR, 0, 255, 0, 16'hAAAA);      // out of range
        send_word(CMD_PAT_WR, 0, 200, 15, 16'hFF00);
        send_word(CMD_SONG_WR, 3, 0, 0, 16'h0001);
        send_word(CMD_SONG_WR, 0, 2, 0, 16'h0001);
        send_word(CMD_TICK, 0, 0, 0, 16'h0);
        send_word(t_cmd'(3'd7), 3, 255, 15, 16'hFFFF);       // unused command
        // rest on bass, unknown pattern on third, unknown tone in lead pattern
        send_word(CMD_SONG_WR, 1, 0, 0, 16'(REST_MARK));
        send_word(CMD_SONG_WR, 2, 1, 0, 16'd200);
        send_word(CMD_PAT_WR, 0, song_mem[0], 3, 16'hFFFF);
        send_word(CMD_MOD_WR, 0, song_mem[0], 2, 16'(BEND_CODE));
        send_word(CMD_MOD_WR, 0, song_mem[0], 15, 16'(BEND_CODE));
        for (int i = 0; i < 8; i++) send_word(CMD_TICK, 0, 0, 0, 16'h0);
        send_word(CMD_RESTART, 0, 0, 0, 16'h0);
        send_word(CMD_TICK, 0, 0, 0, 16'h0);
    endtask

    task automatic random_word();
        int r, ch;
        r = $urandom_range(99);
        if (r < 50)       send_word(CMD_TICK, 0, 0, 0, 16'h0);
        else if (r < 58)  send_word(CMD_TONE_WR, 0, $urandom_range(63), 0, 16'($urandom));
        else if (r < 66)  send_word(CMD_PAT_WR, 0, $urandom_range(15), $urandom_range(15),
                              ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(63)));
        else if (r < 74)  send_word(CMD_MOD_WR, 0, $urandom_range(15), $urandom_range(15),
                              ($urandom_range(1) == 0) ? 16'(BEND_CODE) : 16'($urandom));
        else if (r < 82) begin
            ch = $urandom_range(9);
            send_word(CMD_SONG_WR, $urandom_range(2), $urandom_range(1), 0,
                      (ch < 7) ? 16'($urandom_range(15)) :
                      (ch < 9) ? 16'(REST_MARK) : 16'($urandom));
        end
        else if (r < 88)  send_word(CMD_NOISE_SET, $urandom_range(3), $urandom_range(255),
                                    $urandom_range(15), 16'($urandom));
        else if (r < 91)  send_word(CMD_RESTART, $urandom_range(3), $urandom_range(255),
                                    $urandom_range(15), 16'($urandom));
        // noise: any command, any field
        else send_word(t_cmd'($urandom_range(7)), $urandom_range(3), $urandom_range(255),
                       $urandom_range(15), 16'($urandom));
    endtask

    task automatic test_speed_extremes();
        write_speed(8'd255);
        for (int i = 0; i < 300; i++) send_word(CMD_TICK, 0, 0, 0, 16'h0);
        write_speed(8'd0);
        for (int i = 0; i < 60; i++) random_word();
    endtask

    task automatic test_backpressure();
        write_speed(8'd1);
        @(negedge i_clk);
        hold_cycles = 300;
        for (int i = 0; i < 60; i++) random_word();
    endtask

    task automatic test_random();
        for (int p = 0; p < 4; p++) begin
            write_speed(8'($urandom_range(4, 1)));
            no_idle = (p == 2);
            for (int i = 0; i < 150; i++) random_word();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        foreach (ch_freq[i]) begin
            ch_freq[i] = '0;
            ch_vol[i] = 0;
        end
        noise_lvl[0] = '0;
        noise_lvl[1] = '0;
        step_pos = 0;
        song_pos = 0;
        tick_div = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_load_tables();
        test_directed();
        write_speed(8'd2);
        test_backpressure();
        test_speed_extremes();
        test_random();
        wait_drained();
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
